// File: rtl/qsp_pkg.sv
// Shared types, fixed-point constants, coefficient tables and rounding helpers for the slerp block.
package qsp_pkg;

    // Component format: signed, two integer bits.
    localparam int COMP_WIDTH = 16;
    localparam int COMP_FRAC  = COMP_WIDTH - 2;
    // Fraction t: unsigned Q1.15.
    localparam int T_WIDTH    = 16;
    localparam int T_FRAC     = 15;
    // Internal format: signed Q7.24 in 32 bits.
    localparam int FRAC       = 24;
    localparam int Q_WIDTH    = 32;
    localparam int P_WIDTH    = 2 * Q_WIDTH;
    localparam int W_WIDTH    = Q_WIDTH + 1;
    localparam int R_WIDTH    = P_WIDTH - FRAC;

    localparam int MAX_TERMS     = 8;
    localparam int NUM_TERMS_DEF = 8;

    localparam int COMP_SHIFT = FRAC - COMP_FRAC;
    localparam int T_SHIFT    = FRAC - T_FRAC;
    // Component products carry 2*COMP_FRAC fraction bits.
    localparam int CP_WIDTH   = 2 * COMP_WIDTH;
    localparam int DOT_WIDTH  = CP_WIDTH + 2;
    localparam int DOT_SHIFT  = 2 * COMP_FRAC - FRAC;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [Q_WIDTH-1:0]    q_t;
    typedef logic signed [P_WIDTH-1:0]    prod_t;
    typedef logic signed [W_WIDTH-1:0]    wide_t;
    typedef logic signed [R_WIDTH-1:0]    rnd_t;
    typedef logic signed [CP_WIDTH-1:0]   cprod_t;
    typedef logic signed [DOT_WIDTH-1:0]  dot_t;

    localparam q_t    Q_ONE    = q_t'(1) <<< FRAC;
    localparam q_t    Q_MAX    = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam q_t    Q_MIN    = -Q_MAX;
    localparam wide_t W_MAX    = W_WIDTH'(Q_MAX);
    localparam wide_t W_MIN    = W_WIDTH'(Q_MIN);
    localparam rnd_t  R_MAX    = R_WIDTH'(Q_MAX);
    localparam rnd_t  R_MIN    = R_WIDTH'(Q_MIN);
    localparam prod_t P_HALF   = prod_t'(1) <<< (FRAC - 1);
    localparam dot_t  DOT_HALF = dot_t'(1) <<< (DOT_SHIFT - 1);

    // Series coefficients in Q7.24; the last entry carries the correction factor.
    localparam q_t COEF_U [MAX_TERMS] = '{
        32'sd5592405, 32'sd1677722, 32'sd798915, 32'sd466034,
        32'sd305040,  32'sd215093,  32'sd159782, 32'sd228587
    };
    localparam q_t COEF_V [MAX_TERMS] = '{
        32'sd5592405, 32'sd6710886, 32'sd7190235, 32'sd7456540,
        32'sd7626007, 32'sd7743330, 32'sd7829367, 32'sd14629583
    };

    typedef struct packed {
        comp_t              q1_x;
        comp_t              q1_y;
        comp_t              q1_z;
        comp_t              q1_w;
        comp_t              q2_x;
        comp_t              q2_y;
        comp_t              q2_z;
        comp_t              q2_w;
        logic [T_WIDTH-1:0] t_frac;
    } slerp_in_t;

    typedef struct packed {
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        comp_t out_w;
    } slerp_out_t;

    // Data that rides along the pipeline until the final blend.
    typedef struct packed {
        comp_t [3:0] qa;
        comp_t [3:0] qb;
        q_t          base_t;
        q_t          base_d;
    } qsp_carry_t;

    // Saturate a one-bit-grown sum to the symmetric Q7.24 range.
    function automatic q_t sat_wide(input wide_t x);
        q_t res;
        if (x > W_MAX) begin
            res = Q_MAX;
        end else if (x < W_MIN) begin
            res = Q_MIN;
        end else begin
            res = q_t'(x);
        end
        return res;
    endfunction

    // Round a full product back to Q7.24 (half toward plus infinity) and saturate.
    function automatic q_t rnd_q(input prod_t p);
        prod_t s;
        rnd_t  r;
        q_t    res;
        s = p + P_HALF;
        r = s[P_WIDTH-1:FRAC];
        if (r > R_MAX) begin
            res = Q_MAX;
        end else if (r < R_MIN) begin
            res = Q_MIN;
        end else begin
            res = q_t'(r);
        end
        return res;
    endfunction

endpackage

// File: rtl/qsp_front.sv
// Front pipeline: dot product, squared fractions and the per-term Horner coefficients.
module qsp_front #(
    parameter int NUM_TERMS = qsp_pkg::NUM_TERMS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  qsp_pkg::slerp_in_t                in_data,
    output logic                              out_valid,
    output qsp_pkg::qsp_carry_t               out_carry,
    output qsp_pkg::q_t [NUM_TERMS-1:0]       out_bt,
    output qsp_pkg::q_t [NUM_TERMS-1:0]       out_bd
);

    // Stage 1: component products and the two interpolation bases.
    qsp_pkg::qsp_carry_t        carry1_next, carry1_reg;
    qsp_pkg::cprod_t [3:0]      p1_next, p1_reg;
    logic                       valid1_reg;

    // Stage 2: dot product minus one and squared bases.
    qsp_pkg::qsp_carry_t        carry2_reg;
    qsp_pkg::q_t                xm1_2_next, xm1_2_reg;
    qsp_pkg::q_t                sqt_2_next, sqt_2_reg;
    qsp_pkg::q_t                sqd_2_next, sqd_2_reg;
    qsp_pkg::dot_t              dot_sum;
    qsp_pkg::dot_t              dot_half;
    logic                       valid2_reg;

    // Stage 3: U*sq - V for every term.
    qsp_pkg::qsp_carry_t        carry3_reg;
    qsp_pkg::q_t                xm1_3_reg;
    qsp_pkg::q_t [NUM_TERMS-1:0] ct_3_next, ct_3_reg;
    qsp_pkg::q_t [NUM_TERMS-1:0] cd_3_next, cd_3_reg;
    logic                       valid3_reg;

    // Stage 4: scale by the dot product term.
    qsp_pkg::qsp_carry_t        carry4_reg;
    qsp_pkg::q_t [NUM_TERMS-1:0] bt_4_next, bt_4_reg;
    qsp_pkg::q_t [NUM_TERMS-1:0] bd_4_next, bd_4_reg;
    logic                       valid4_reg;

    always_comb begin
        carry1_next.qa[0]  = in_data.q1_x;
        carry1_next.qa[1]  = in_data.q1_y;
        carry1_next.qa[2]  = in_data.q1_z;
        carry1_next.qa[3]  = in_data.q1_w;
        carry1_next.qb[0]  = in_data.q2_x;
        carry1_next.qb[1]  = in_data.q2_y;
        carry1_next.qb[2]  = in_data.q2_z;
        carry1_next.qb[3]  = in_data.q2_w;
        carry1_next.base_t = qsp_pkg::q_t'(in_data.t_frac) <<< qsp_pkg::T_SHIFT;
        carry1_next.base_d = qsp_pkg::Q_ONE - carry1_next.base_t;
        for (int k = 0; k < 4; k++) begin
            p1_next[k] = qsp_pkg::cprod_t'(carry1_next.qa[k])
                       * qsp_pkg::cprod_t'(carry1_next.qb[k]);
        end
    end

    always_comb begin
        dot_sum = qsp_pkg::DOT_WIDTH'(p1_reg[0]) + qsp_pkg::DOT_WIDTH'(p1_reg[1])
                + qsp_pkg::DOT_WIDTH'(p1_reg[2]) + qsp_pkg::DOT_WIDTH'(p1_reg[3]);
        dot_half = dot_sum + qsp_pkg::DOT_HALF;
        xm1_2_next = qsp_pkg::sat_wide(
            qsp_pkg::W_WIDTH'($signed(dot_half[qsp_pkg::DOT_WIDTH-1:qsp_pkg::DOT_SHIFT]))
            - qsp_pkg::W_WIDTH'(qsp_pkg::Q_ONE));
        sqt_2_next = qsp_pkg::rnd_q(qsp_pkg::prod_t'(carry1_reg.base_t)
                                  * qsp_pkg::prod_t'(carry1_reg.base_t));
        sqd_2_next = qsp_pkg::rnd_q(qsp_pkg::prod_t'(carry1_reg.base_d)
                                  * qsp_pkg::prod_t'(carry1_reg.base_d));
    end

    always_comb begin
        for (int i = 0; i < NUM_TERMS; i++) begin
            ct_3_next[i] = qsp_pkg::sat_wide(
                qsp_pkg::W_WIDTH'(qsp_pkg::rnd_q(qsp_pkg::prod_t'(qsp_pkg::COEF_U[i])
                                               * qsp_pkg::prod_t'(sqt_2_reg)))
                - qsp_pkg::W_WIDTH'(qsp_pkg::COEF_V[i]));
            cd_3_next[i] = qsp_pkg::sat_wide(
                qsp_pkg::W_WIDTH'(qsp_pkg::rnd_q(qsp_pkg::prod_t'(qsp_pkg::COEF_U[i])
                                               * qsp_pkg::prod_t'(sqd_2_reg)))
                - qsp_pkg::W_WIDTH'(qsp_pkg::COEF_V[i]));
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TERMS; i++) begin
            bt_4_next[i] = qsp_pkg::rnd_q(qsp_pkg::prod_t'(ct_3_reg[i])
                                        * qsp_pkg::prod_t'(xm1_3_reg));
            bd_4_next[i] = qsp_pkg::rnd_q(qsp_pkg::prod_t'(cd_3_reg[i])
                                        * qsp_pkg::prod_t'(xm1_3_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            carry1_reg <= carry1_next;
            p1_reg     <= p1_next;
            carry2_reg <= carry1_reg;
            xm1_2_reg  <= xm1_2_next;
            sqt_2_reg  <= sqt_2_next;
            sqd_2_reg  <= sqd_2_next;
            carry3_reg <= carry2_reg;
            xm1_3_reg  <= xm1_2_reg;
            ct_3_reg   <= ct_3_next;
            cd_3_reg   <= cd_3_next;
            carry4_reg <= carry3_reg;
            bt_4_reg   <= bt_4_next;
            bd_4_reg   <= bd_4_next;
        end
    end

    assign out_valid = valid4_reg;
    assign out_carry = carry4_reg;
    assign out_bt    = bt_4_reg;
    assign out_bd    = bd_4_reg;

endmodule

// File: rtl/qsp_horner.sv
// One Horner step for both weight chains: acc = 1 + b[term] * acc.
module qsp_horner #(
    parameter int NUM_TERMS = qsp_pkg::NUM_TERMS_DEF,
    parameter int STEP      = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  qsp_pkg::qsp_carry_t               in_carry,
    input  qsp_pkg::q_t [NUM_TERMS-1:0]       in_bt,
    input  qsp_pkg::q_t [NUM_TERMS-1:0]       in_bd,
    input  qsp_pkg::q_t                       in_acc_t,
    input  qsp_pkg::q_t                       in_acc_d,
    output logic                              out_valid,
    output qsp_pkg::qsp_carry_t               out_carry,
    output qsp_pkg::q_t [NUM_TERMS-1:0]       out_bt,
    output qsp_pkg::q_t [NUM_TERMS-1:0]       out_bd,
    output qsp_pkg::q_t                       out_acc_t,
    output qsp_pkg::q_t                       out_acc_d
);

    // The chain runs from the highest term down to term zero.
    localparam int TERM = NUM_TERMS - 1 - STEP;

    logic                        valid_reg;
    qsp_pkg::qsp_carry_t         carry_reg;
    qsp_pkg::q_t [NUM_TERMS-1:0] bt_reg, bd_reg;
    qsp_pkg::q_t                 acc_t_next, acc_t_reg;
    qsp_pkg::q_t                 acc_d_next, acc_d_reg;

    always_comb begin
        acc_t_next = qsp_pkg::sat_wide(qsp_pkg::W_WIDTH'(qsp_pkg::Q_ONE)
            + qsp_pkg::W_WIDTH'(qsp_pkg::rnd_q(qsp_pkg::prod_t'(in_bt[TERM])
                                             * qsp_pkg::prod_t'(in_acc_t))));
        acc_d_next = qsp_pkg::sat_wide(qsp_pkg::W_WIDTH'(qsp_pkg::Q_ONE)
            + qsp_pkg::W_WIDTH'(qsp_pkg::rnd_q(qsp_pkg::prod_t'(in_bd[TERM])
                                             * qsp_pkg::prod_t'(in_acc_d))));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            carry_reg <= in_carry;
            bt_reg    <= in_bt;
            bd_reg    <= in_bd;
            acc_t_reg <= acc_t_next;
            acc_d_reg <= acc_d_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_carry = carry_reg;
    assign out_bt    = bt_reg;
    assign out_bd    = bd_reg;
    assign out_acc_t = acc_t_reg;
    assign out_acc_d = acc_d_reg;

endmodule

// File: rtl/qsp_blend.sv
// Back end: final weights, weighted sum of the two quaternions and the saturating output register.
module qsp_blend (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  qsp_pkg::qsp_carry_t   in_carry,
    input  qsp_pkg::q_t           in_acc_t,
    input  qsp_pkg::q_t           in_acc_d,
    output logic                  out_valid,
    output qsp_pkg::slerp_out_t   out_data
);

    localparam int O_WIDTH = qsp_pkg::Q_WIDTH + 2;
    localparam int C_WIDTH = O_WIDTH - qsp_pkg::COMP_SHIFT;

    typedef logic signed [O_WIDTH-1:0] osum_t;
    typedef logic signed [C_WIDTH-1:0] ocomp_t;

    localparam osum_t  O_HALF = osum_t'(1) <<< (qsp_pkg::COMP_SHIFT - 1);
    localparam ocomp_t C_MAX  = C_WIDTH'(qsp_pkg::comp_t'({1'b0,
                                    {(qsp_pkg::COMP_WIDTH-1){1'b1}}}));
    localparam ocomp_t C_MIN  = C_WIDTH'(qsp_pkg::comp_t'({1'b1,
                                    {(qsp_pkg::COMP_WIDTH-1){1'b0}}}));

    // Weight stage.
    logic                  valid_w_reg;
    qsp_pkg::qsp_carry_t   carry_w_reg;
    qsp_pkg::q_t           f0_next, f0_reg;
    qsp_pkg::q_t           f1_next, f1_reg;

    // Scaled component stage.
    logic                  valid_f_reg;
    qsp_pkg::q_t [3:0]     pa_next, pa_reg;
    qsp_pkg::q_t [3:0]     pb_next, pb_reg;

    // Output register.
    logic                  valid_o_reg;
    qsp_pkg::comp_t [3:0]  o_next, o_reg;
    osum_t  [3:0]          osum;
    ocomp_t [3:0]          ocomp;

    always_comb begin
        f0_next = qsp_pkg::rnd_q(qsp_pkg::prod_t'(in_carry.base_t)
                               * qsp_pkg::prod_t'(in_acc_t));
        f1_next = qsp_pkg::rnd_q(qsp_pkg::prod_t'(in_carry.base_d)
                               * qsp_pkg::prod_t'(in_acc_d));
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pa_next[k] = qsp_pkg::rnd_q(qsp_pkg::prod_t'(f0_reg) * qsp_pkg::prod_t'(
                qsp_pkg::q_t'(carry_w_reg.qa[k]) <<< qsp_pkg::COMP_SHIFT));
            pb_next[k] = qsp_pkg::rnd_q(qsp_pkg::prod_t'(f1_reg) * qsp_pkg::prod_t'(
                qsp_pkg::q_t'(carry_w_reg.qb[k]) <<< qsp_pkg::COMP_SHIFT));
        end
    end

    // Add the two halves, round to the component format and clamp.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            osum[k]  = O_WIDTH'(pa_reg[k]) + O_WIDTH'(pb_reg[k]) + O_HALF;
            ocomp[k] = osum[k][O_WIDTH-1:qsp_pkg::COMP_SHIFT];
            if (ocomp[k] > C_MAX) begin
                o_next[k] = qsp_pkg::comp_t'(C_MAX);
            end else if (ocomp[k] < C_MIN) begin
                o_next[k] = qsp_pkg::comp_t'(C_MIN);
            end else begin
                o_next[k] = qsp_pkg::comp_t'(ocomp[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_w_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_o_reg <= 1'b0;
        end else if (en) begin
            valid_w_reg <= in_valid;
            valid_f_reg <= valid_w_reg;
            valid_o_reg <= valid_f_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            carry_w_reg <= in_carry;
            f0_reg      <= f0_next;
            f1_reg      <= f1_next;
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            o_reg       <= o_next;
        end
    end

    assign out_valid      = valid_o_reg;
    assign out_data.out_x = o_reg[0];
    assign out_data.out_y = o_reg[1];
    assign out_data.out_z = o_reg[2];
    assign out_data.out_w = o_reg[3];

endmodule

// File: rtl/quaternion_slerp_polynomial.sv
// Top level of the pipelined polynomial quaternion slerp.
//
// Usage: a transaction on the s_ channel carries two quaternions q1 and q2
// (signed Q2.14 components) and a fraction t (unsigned Q1.15, 32768 = 1.0).
// Each input transaction produces exactly one transaction on the m_ channel
// holding f0*q1 + f1*q2 with saturated Q2.14 components, where f0 is the
// series weight built from t and f1 the one built from 1 - t. With t = 0 the
// result is q2, with t = 1 it is q1. No hemisphere flip is applied.
//
// Throughput is one transaction per cycle while m_ready does not stall the
// pipeline. From input acceptance to m_valid a transaction passes four
// front stages, one stage per Horner term and three blend stages. The depth
// is set by the Horner chain, which needs one multiply per term.
//
// aresetn is synchronous and active low; it clears every valid bit, so the
// pipeline comes up empty. When the receiver holds m_ready low while a result
// is waiting, the whole pipeline freezes and s_ready drops in the same cycle;
// nothing in flight is lost or repeated. Bubbles pass through in order.
module quaternion_slerp_polynomial #(
    parameter int NUM_TERMS = qsp_pkg::NUM_TERMS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qsp_pkg::slerp_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output qsp_pkg::slerp_out_t  m_data
);

    // Global advance: move when the output register is empty or being drained.
    logic en;

    logic                        valid_chain [NUM_TERMS+1];
    qsp_pkg::qsp_carry_t         carry_chain [NUM_TERMS+1];
    qsp_pkg::q_t                 acct_chain  [NUM_TERMS+1];
    qsp_pkg::q_t                 accd_chain  [NUM_TERMS+1];
    qsp_pkg::q_t [NUM_TERMS-1:0] bt_chain    [NUM_TERMS];
    qsp_pkg::q_t [NUM_TERMS-1:0] bd_chain    [NUM_TERMS];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    qsp_front #(
        .NUM_TERMS (NUM_TERMS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (valid_chain[0]),
        .out_carry (carry_chain[0]),
        .out_bt    (bt_chain[0]),
        .out_bd    (bd_chain[0])
    );

    // Both Horner chains start from an accumulator of one.
    assign acct_chain[0] = qsp_pkg::Q_ONE;
    assign accd_chain[0] = qsp_pkg::Q_ONE;

    for (genvar h = 0; h < NUM_TERMS; h++) begin : g_horner
        if (h < NUM_TERMS - 1) begin : g_mid
            qsp_horner #(
                .NUM_TERMS (NUM_TERMS),
                .STEP      (h)
            ) u_horner (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (valid_chain[h]),
                .in_carry  (carry_chain[h]),
                .in_bt     (bt_chain[h]),
                .in_bd     (bd_chain[h]),
                .in_acc_t  (acct_chain[h]),
                .in_acc_d  (accd_chain[h]),
                .out_valid (valid_chain[h+1]),
                .out_carry (carry_chain[h+1]),
                .out_bt    (bt_chain[h+1]),
                .out_bd    (bd_chain[h+1]),
                .out_acc_t (acct_chain[h+1]),
                .out_acc_d (accd_chain[h+1])
            );
        end else begin : g_last
            // The coefficient arrays are not needed after the last term.
            qsp_horner #(
                .NUM_TERMS (NUM_TERMS),
                .STEP      (h)
            ) u_horner (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (valid_chain[h]),
                .in_carry  (carry_chain[h]),
                .in_bt     (bt_chain[h]),
                .in_bd     (bd_chain[h]),
                .in_acc_t  (acct_chain[h]),
                .in_acc_d  (accd_chain[h]),
                .out_valid (valid_chain[h+1]),
                .out_carry (carry_chain[h+1]),
                .out_bt    (),
                .out_bd    (),
                .out_acc_t (acct_chain[h+1]),
                .out_acc_d (accd_chain[h+1])
            );
        end
    end

    qsp_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_chain[NUM_TERMS]),
        .in_carry  (carry_chain[NUM_TERMS]),
        .in_acc_t  (acct_chain[NUM_TERMS]),
        .in_acc_d  (accd_chain[NUM_TERMS]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule
